### src/bod_pkg.sv
// ----------------------------------------------------------------------------
// bod_pkg: shared types and constants for the object identifier decoder
// Holds the result layout, status codes, parse phases and fixed constants.
// ----------------------------------------------------------------------------
package bod_pkg;

  localparam logic [7:0] OidTag       = 8'h06;
  localparam logic [7:0] CapacityRst  = 8'd32;
  localparam logic [2:0] MaxSeptets   = 3'd5;
  localparam int unsigned ArcW        = 32;
  localparam int unsigned IdxW        = 8;

  typedef enum logic [2:0] {
    ST_ARC      = 3'd0,
    ST_BAD_TAG  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ArcW-1:0] arc_value;
    logic [IdxW-1:0] arc_index;
    status_e         status;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } decode_t;

endpackage

### src/ber_oid_decoder.sv
// ----------------------------------------------------------------------------
// ber_oid_decoder: BER object identifier decoder
// Parses tag, length and content bytes and emits one item per decoded arc or error.
// ----------------------------------------------------------------------------
// Each accepted byte is held in an input register and decoded from there into
// zero, one or two result items, which enter a two-entry output queue. One
// byte is taken per cycle while the queue has room; the first content byte
// yields two items, so the output port sets the pace there. Errors produce a
// single item with tlast set, and the decoder then waits for a fresh tag byte.
module ber_oid_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_in
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // arc_value [31:0], arc_index [39:32], status [42:40], zero fill [47:43]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [7:0] capacity_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       consume;
  logic       room;
  logic       pop;
  bod_pkg::decode_t dec;
  bod_pkg::result_t head;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign consume       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= bod_pkg::CapacityRst;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  bod_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (in_byte_q),
    .consume_i  (consume),
    .capacity_i (capacity_q),
    .dec_o      (dec)
  );

  bod_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dec_i   (dec),
    .push_i  (consume),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.status, head.arc_index, head.arc_value};
  assign m_axis_tlast = head.last;

endmodule

### src/bod_core.sv
// ----------------------------------------------------------------------------
// bod_core: parse state and per-byte decode
// Decodes the registered input byte into up to two results and updates the
// parse state when the byte is consumed.
// ----------------------------------------------------------------------------
module bod_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  logic               consume_i,
  input  logic [7:0]         capacity_i,
  output bod_pkg::decode_t   dec_o
);

  bod_pkg::phase_e phase_q, phase_d;
  logic [6:0]  bytes_left_q, bytes_left_d;
  logic [31:0] arc_accum_q, arc_accum_d;
  logic [2:0]  septet_q, septet_d;
  logic [7:0]  arcs_done_q, arcs_done_d;

  logic [15:0] div_prod;
  logic [2:0]  quot;
  logic [7:0]  remd;
  logic [6:0]  bl_next;
  logic        done;
  logic [31:0] acc_base;
  logic [31:0] acc_new;
  logic [2:0]  septet_new;
  logic [7:0]  arcs_less;

  assign div_prod   = byte_i * 8'd205;
  assign quot       = div_prod[15:13];
  assign remd       = byte_i - ({5'd0, quot} * 8'd40);
  assign bl_next    = bytes_left_q - 7'd1;
  assign done       = (bl_next == 7'd0);
  assign acc_base   = (septet_q == 3'd0) ? 32'd0 : arc_accum_q;
  assign acc_new    = {acc_base[24:0], byte_i[6:0]};
  assign septet_new = septet_q + 3'd1;
  assign arcs_less  = arcs_done_q - 8'd1;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    arc_accum_d  = arc_accum_q;
    septet_d     = septet_q;
    arcs_done_d  = arcs_done_q;
    dec_o.count  = 2'd0;
    dec_o.res0   = '{arc_value: '0, arc_index: '0, status: bod_pkg::ST_ARC, last: 1'b0};
    dec_o.res1   = '{arc_value: '0, arc_index: '0, status: bod_pkg::ST_ARC, last: 1'b0};
    case (phase_q)
      bod_pkg::PH_LEN: begin
        if ((byte_i == 8'd0) || byte_i[7]) begin
          phase_d           = bod_pkg::PH_TAG;
          bytes_left_d      = '0;
          dec_o.count       = 2'd1;
          dec_o.res0.status = bod_pkg::ST_BAD_LEN;
          dec_o.res0.last   = 1'b1;
        end else begin
          phase_d      = bod_pkg::PH_BODY;
          bytes_left_d = byte_i[6:0];
          arc_accum_d  = '0;
          septet_d     = '0;
          arcs_done_d  = '0;
        end
      end
      bod_pkg::PH_BODY: begin
        bytes_left_d = bl_next;
        if (arcs_done_q == 8'd0) begin
          dec_o.count          = 2'd2;
          dec_o.res0.arc_value = {29'd0, quot};
          dec_o.res1.arc_value = {24'd0, remd};
          dec_o.res1.arc_index = 8'd1;
          dec_o.res1.last      = done;
          arcs_done_d          = 8'd2;
        end else if ((septet_q == 3'd0) && (arcs_less >= capacity_i)) begin
          dec_o.count          = 2'd1;
          dec_o.res0.arc_index = arcs_done_q;
          dec_o.res0.status    = bod_pkg::ST_TOO_MANY;
          dec_o.res0.last      = 1'b1;
        end else if (!byte_i[7] || (septet_new >= bod_pkg::MaxSeptets)) begin
          dec_o.count          = 2'd1;
          dec_o.res0.arc_value = acc_new;
          dec_o.res0.arc_index = arcs_done_q;
          dec_o.res0.last      = done;
          arcs_done_d          = arcs_done_q + 8'd1;
          arc_accum_d          = '0;
          septet_d             = '0;
        end else if (done) begin
          dec_o.count          = 2'd1;
          dec_o.res0.arc_index = arcs_done_q;
          dec_o.res0.status    = bod_pkg::ST_TRUNC;
          dec_o.res0.last      = 1'b1;
        end else begin
          arc_accum_d = acc_new;
          septet_d    = septet_new;
        end
        if (dec_o.res0.last || dec_o.res1.last) begin
          phase_d      = bod_pkg::PH_TAG;
          bytes_left_d = '0;
          arc_accum_d  = '0;
          septet_d     = '0;
          arcs_done_d  = '0;
        end
      end
      default: begin
        phase_d      = bod_pkg::PH_TAG;
        bytes_left_d = '0;
        arc_accum_d  = '0;
        septet_d     = '0;
        arcs_done_d  = '0;
        if (byte_i != bod_pkg::OidTag) begin
          dec_o.count       = 2'd1;
          dec_o.res0.status = bod_pkg::ST_BAD_TAG;
          dec_o.res0.last   = 1'b1;
        end else begin
          phase_d = bod_pkg::PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= bod_pkg::PH_TAG;
      bytes_left_q <= '0;
      arc_accum_q  <= '0;
      septet_q     <= '0;
      arcs_done_q  <= '0;
    end else if (consume_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      arc_accum_q  <= arc_accum_d;
      septet_q     <= septet_d;
      arcs_done_q  <= arcs_done_d;
    end
  end

endmodule

### src/bod_outq.sv
// ----------------------------------------------------------------------------
// bod_outq: two-entry result queue
// Takes up to two results per cycle when there is room and hands them out one per cycle while they are popped.
// ----------------------------------------------------------------------------
module bod_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bod_pkg::decode_t   dec_i,
  input  logic               push_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic               valid_o,
  output bod_pkg::result_t   head_o
);

  bod_pkg::result_t slot_q [2];
  bod_pkg::result_t slot_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] keep;
  logic [1:0] add;

  assign keep    = count_q - {1'b0, pop_i};
  assign add     = push_i ? dec_i.count : 2'd0;
  assign room_o  = ({1'b0, dec_i.count} + {1'b0, keep}) <= 3'd2;
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[0];
  assign count_d = keep + add;

  always_comb begin
    slot_d[0] = pop_i ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    if (keep == 2'd0) begin
      slot_d[0] = dec_i.res0;
      slot_d[1] = dec_i.res1;
    end else if (keep == 2'd1) begin
      slot_d[1] = dec_i.res0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

### src/bod_checker.sv
// ----------------------------------------------------------------------------
// bod_checker: port-level checks for the decoder
// Watches the result stream of the top level and flags malformed items.
// ----------------------------------------------------------------------------
module bod_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[42:40] != 3'd0) |-> m_axis_tlast)
    else $error("Error item without tlast.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[42:40] != 3'd0) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("Error item with nonzero arc value.");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:43] == 5'd0) && (m_axis_tdata[42:40] <= 3'd4))
    else $error("Bad status code or fill bits.");

endmodule

bind ber_oid_decoder bod_checker u_bod_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
